// File: rtl/core/c9rm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c9rm_pkg
// Shared widths for the ninth cyclotomic ring multiplier.
// ----------------------------------------------------------------------------
package c9rm_pkg;

  localparam int COEF_WIDTH = 16;
  localparam int OUT_WIDTH  = 35;
  localparam int NCOEF      = 6;
  localparam int NDEG       = 2 * NCOEF - 1;
  localparam int PROD_WIDTH = 2 * COEF_WIDTH;

endpackage

// File: rtl/core/c9rm_operand_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c9rm_operand_if
// Valid/ready channel carrying the two operands, six coefficients each.
// ----------------------------------------------------------------------------
interface c9rm_operand_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [c9rm_pkg::COEF_WIDTH-1:0] a_coef0;
  logic signed [c9rm_pkg::COEF_WIDTH-1:0] a_coef1;
  logic signed [c9rm_pkg::COEF_WIDTH-1:0] a_coef2;
  logic signed [c9rm_pkg::COEF_WIDTH-1:0] a_coef3;
  logic signed [c9rm_pkg::COEF_WIDTH-1:0] a_coef4;
  logic signed [c9rm_pkg::COEF_WIDTH-1:0] a_coef5;
  logic signed [c9rm_pkg::COEF_WIDTH-1:0] b_coef0;
  logic signed [c9rm_pkg::COEF_WIDTH-1:0] b_coef1;
  logic signed [c9rm_pkg::COEF_WIDTH-1:0] b_coef2;
  logic signed [c9rm_pkg::COEF_WIDTH-1:0] b_coef3;
  logic signed [c9rm_pkg::COEF_WIDTH-1:0] b_coef4;
  logic signed [c9rm_pkg::COEF_WIDTH-1:0] b_coef5;

  modport source (
    output valid, a_coef0, a_coef1, a_coef2, a_coef3, a_coef4, a_coef5,
           b_coef0, b_coef1, b_coef2, b_coef3, b_coef4, b_coef5,
    input  ready
  );

  modport sink (
    input  valid, a_coef0, a_coef1, a_coef2, a_coef3, a_coef4, a_coef5,
           b_coef0, b_coef1, b_coef2, b_coef3, b_coef4, b_coef5,
    output ready
  );
endinterface

// File: rtl/core/c9rm_product_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c9rm_product_if
// Valid/ready channel carrying the six reduced product coefficients.
// ----------------------------------------------------------------------------
interface c9rm_product_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [c9rm_pkg::OUT_WIDTH-1:0] p_coef0;
  logic signed [c9rm_pkg::OUT_WIDTH-1:0] p_coef1;
  logic signed [c9rm_pkg::OUT_WIDTH-1:0] p_coef2;
  logic signed [c9rm_pkg::OUT_WIDTH-1:0] p_coef3;
  logic signed [c9rm_pkg::OUT_WIDTH-1:0] p_coef4;
  logic signed [c9rm_pkg::OUT_WIDTH-1:0] p_coef5;

  modport source (
    output valid, p_coef0, p_coef1, p_coef2, p_coef3, p_coef4, p_coef5,
    input  ready
  );

  modport sink (
    input  valid, p_coef0, p_coef1, p_coef2, p_coef3, p_coef4, p_coef5,
    output ready
  );
endinterface

// File: rtl/core/cyclotomic9_ring_multiply_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cyclotomic9_ring_multiply_top
// Product of two elements of Z[z], z^6 + z^3 + 1 = 0, on basis 1..z^5.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while the output is not stalled (product.ready low).
// Stages are multiply, degree sum, fold; each ends in a register.
// Each stage holds its item under backpressure and fills bubbles ahead.
// Reset (synchronous) clears the stage valid bits only.
// ----------------------------------------------------------------------------
module cyclotomic9_ring_multiply_top (
  input  logic            clk,
  input  logic            rst,
  c9rm_operand_if.sink    operand,
  c9rm_product_if.source  product
);

  localparam int CW = c9rm_pkg::COEF_WIDTH;
  localparam int OW = c9rm_pkg::OUT_WIDTH;
  localparam int PW = c9rm_pkg::PROD_WIDTH;
  localparam int NC = c9rm_pkg::NCOEF;
  localparam int ND = c9rm_pkg::NDEG;

  logic signed [CW-1:0] a_in [NC];
  logic signed [CW-1:0] b_in [NC];

  logic                 v1;
  logic                 v2;
  logic                 v3;
  logic                 adv1;
  logic                 adv2;
  logic                 adv3;

  logic signed [PW-1:0] prod      [NC][NC];
  logic signed [OW-1:0] dsum      [ND];
  logic signed [OW-1:0] dsum_next [ND];
  logic signed [OW-1:0] pc        [NC];
  logic signed [OW-1:0] pc_next   [NC];

  assign a_in[0] = operand.a_coef0;
  assign a_in[1] = operand.a_coef1;
  assign a_in[2] = operand.a_coef2;
  assign a_in[3] = operand.a_coef3;
  assign a_in[4] = operand.a_coef4;
  assign a_in[5] = operand.a_coef5;
  assign b_in[0] = operand.b_coef0;
  assign b_in[1] = operand.b_coef1;
  assign b_in[2] = operand.b_coef2;
  assign b_in[3] = operand.b_coef3;
  assign b_in[4] = operand.b_coef4;
  assign b_in[5] = operand.b_coef5;

  assign adv3          = !v3 || product.ready;
  assign adv2          = !v2 || adv3;
  assign adv1          = !v1 || adv2;
  assign operand.ready = adv1;

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= operand.valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
  end

  // stage 1: all 36 partial products
  always_ff @(posedge clk) begin
    if (adv1) begin
      for (int i = 0; i < NC; i++) begin
        for (int j = 0; j < NC; j++) begin
          prod[i][j] <= PW'(a_in[i] * b_in[j]);
        end
      end
    end
  end

  // stage 2: sum by degree i+j
  always_comb begin
    for (int s = 0; s < ND; s++) begin
      dsum_next[s] = '0;
    end
    for (int i = 0; i < NC; i++) begin
      for (int j = 0; j < NC; j++) begin
        dsum_next[i+j] = dsum_next[i+j] + OW'(prod[i][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      dsum <= dsum_next;
    end
  end

  // stage 3: fold degrees 6..10 back; z^6 = -z^3 - 1, z^9 = 1
  always_comb begin
    pc_next[0] = dsum[0] - dsum[6] + dsum[9];
    pc_next[1] = dsum[1] - dsum[7] + dsum[10];
    pc_next[2] = dsum[2] - dsum[8];
    pc_next[3] = dsum[3] - dsum[6];
    pc_next[4] = dsum[4] - dsum[7];
    pc_next[5] = dsum[5] - dsum[8];
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      pc <= pc_next;
    end
  end

  assign product.valid   = v3;
  assign product.p_coef0 = pc[0];
  assign product.p_coef1 = pc[1];
  assign product.p_coef2 = pc[2];
  assign product.p_coef3 = pc[3];
  assign product.p_coef4 = pc[4];
  assign product.p_coef5 = pc[5];

  a_empty_accepts: assert property (@(posedge clk) disable iff (rst)
    (!v1 && !v2 && !v3) |-> operand.ready)
    else $error("empty pipeline refused an item");

  a_stage1_holds: assert property (@(posedge clk) disable iff (rst)
    (v1 && !adv2) |=> (v1 && $stable(prod[5][5]) && $stable(prod[0][0])))
    else $error("stage 1 item lost under stall");

  a_stage2_holds: assert property (@(posedge clk) disable iff (rst)
    (v2 && !adv3) |=> (v2 && $stable(dsum[6]) && $stable(dsum[0])))
    else $error("stage 2 item lost under stall");

  a_stage2_to_out: assert property (@(posedge clk) disable iff (rst)
    (v2 && adv3) |=> (product.valid && product.p_coef2 == $past(pc_next[2])))
    else $error("stage 2 item did not reach the output");

endmodule
